>>> rtl/s256_pkg.sv
// Shared types and constants for the SHA-256 byte stream hasher.
// Holds the sequencer state type, working variable struct, round and IV tables.
// No dependencies.
package s256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    logic [31:0] f;
    logic [31:0] g;
    logic [31:0] h;
  } vars_t;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] LAST_POS  = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD = 3'd7;

  localparam vars_t HASH_INIT = '{
    a: 32'h6a09e667, b: 32'hbb67ae85, c: 32'h3c6ef372, d: 32'ha54ff53a,
    e: 32'h510e527f, f: 32'h9b05688c, g: 32'h1f83d9ab, h: 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

>>> rtl/s256_round.sv
// One SHA-256 compression round plus one message schedule step.
// Shared by every round of the compression sequencer.
// Depends on s256_pkg.
module s256_round import s256_pkg::*; (
  input  vars_t       v,
  input  logic [31:0] k,
  input  logic [31:0] w0,
  input  logic [31:0] w1,
  input  logic [31:0] w9,
  input  logic [31:0] w14,
  output vars_t       v_next,
  output logic [31:0] w_new
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] big_s0;
  logic [31:0] big_s1;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] small_s0;
  logic [31:0] small_s1;

  always_comb begin
    big_s1 = rotr(v.e, 6) ^ rotr(v.e, 11) ^ rotr(v.e, 25);
    big_s0 = rotr(v.a, 2) ^ rotr(v.a, 13) ^ rotr(v.a, 22);
    ch     = (v.e & v.f) ^ (~v.e & v.g);
    maj    = (v.a & v.b) ^ (v.a & v.c) ^ (v.b & v.c);
    t1     = v.h + big_s1 + ch + k + w0;
    t2     = big_s0 + maj;

    v_next.h = v.g;
    v_next.g = v.f;
    v_next.f = v.e;
    v_next.e = v.d + t1;
    v_next.d = v.c;
    v_next.c = v.b;
    v_next.b = v.a;
    v_next.a = t1 + t2;

    small_s0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    small_s1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    w_new    = w0 + small_s0 + w9 + small_s1;
  end

endmodule

>>> rtl/sha256_byte_stream_hasher.sv
// SHA-256 byte stream hasher: absorbs one byte per transaction, emits 8 digest words.
// Absorb: a 64th byte starts compression (64 rounds, then the hash update), with in_ready low.
// Finish: zero and length padding to a full block, compression, 8 words; >55 pending adds a padded block more.
// Throughput is set by the single shared round unit; no byte is taken while a block compresses.
// Synchronous reset loads the initial hash and zeroes the counts; block store kept.
// Depends on s256_pkg and s256_round.
module sha256_byte_stream_hasher import s256_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  state_t       state;
  state_t       state_next;
  logic [5:0]   pending;
  logic [60:0]  msg_count;
  logic         finishing;
  logic         extra;
  logic [5:0]   round;
  logic [2:0]   word_cnt;
  vars_t        hash;
  vars_t        v;
  vars_t        v_next;
  logic [511:0] block;
  logic [63:0]  len_bits;
  logic [31:0]  w_new;

  logic         in_fire;
  logic         push_en;
  logic         len_phase;
  logic [7:0]   push_byte;
  logic         full;

  s256_round u_round (
    .v      (v),
    .k      (ROUND_K[round]),
    .w0     (block[511:480]),
    .w1     (block[479:448]),
    .w9     (block[223:192]),
    .w14    (block[63:32]),
    .v_next (v_next),
    .w_new  (w_new)
  );

  always_comb begin
    in_ready    = (state == ST_IDLE);
    out_valid   = (state == ST_OUT);
    digest_word = hash.a;
    word_index  = word_cnt;
    last_word   = (word_cnt == LAST_WORD);
    in_fire     = in_valid && in_ready;
    len_phase   = (pending >= LEN_START) && !extra;
    push_en     = in_fire || (state == ST_PAD);
    if (in_fire) begin
      push_byte = (operation == OP_FINISH) ? PAD_BYTE : data_byte;
    end else begin
      push_byte = len_phase ? len_bits[63:56] : 8'h00;
    end
    full = push_en && (pending == LAST_POS);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (full) begin
            state_next = ST_ROUND;
          end else if (operation == OP_FINISH) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (full) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round == LAST_ROUND) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!finishing) begin
          state_next = ST_IDLE;
        end else if (extra) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready && word_cnt == LAST_WORD) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pending   <= '0;
      msg_count <= '0;
      finishing <= 1'b0;
      extra     <= 1'b0;
      round     <= '0;
      word_cnt  <= '0;
      hash      <= HASH_INIT;
    end else begin
      state <= state_next;
      if (push_en) begin
        pending <= pending + 6'd1;
      end
      if (in_fire && operation == OP_ABSORB) begin
        msg_count <= msg_count + 61'd1;
      end
      if (in_fire && operation == OP_FINISH) begin
        msg_count <= '0;
        finishing <= 1'b1;
        extra     <= (pending >= LEN_START);
      end
      if (full) begin
        round <= '0;
      end else if (state == ST_ROUND) begin
        round <= round + 6'd1;
      end
      if (state == ST_UPDATE) begin
        hash.a <= hash.a + v.a;
        hash.b <= hash.b + v.b;
        hash.c <= hash.c + v.c;
        hash.d <= hash.d + v.d;
        hash.e <= hash.e + v.e;
        hash.f <= hash.f + v.f;
        hash.g <= hash.g + v.g;
        hash.h <= hash.h + v.h;
        if (finishing && extra) begin
          extra <= 1'b0;
        end
      end
      if (state == ST_OUT && out_ready) begin
        word_cnt <= word_cnt + 3'd1;
        if (word_cnt == LAST_WORD) begin
          hash      <= HASH_INIT;
          finishing <= 1'b0;
        end else begin
          hash <= {hash.b, hash.c, hash.d, hash.e, hash.f, hash.g, hash.h, hash.a};
        end
      end
    end
  end

  // block doubles as the sixteen-word schedule window during the rounds
  always_ff @(posedge clk) begin
    if (push_en) begin
      block <= {block[503:0], push_byte};
    end else if (state == ST_ROUND) begin
      block <= {block[479:0], w_new};
    end
    if (in_fire && operation == OP_FINISH) begin
      len_bits <= {msg_count, 3'b000};
    end else if (state == ST_PAD && len_phase) begin
      len_bits <= {len_bits[55:0], 8'h00};
    end
    if (full) begin
      v <= hash;
    end else if (state == ST_ROUND) begin
      v <= v_next;
    end
  end

`ifndef SYNTH
  a_full_starts_round: assert property (@(posedge clk) disable iff (rst)
    (in_fire && operation == OP_ABSORB && pending == LAST_POS)
      |=> (state == ST_ROUND && round == 6'd0 && pending == 6'd0))
    else $error("full block did not start compression");

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && round == LAST_ROUND) |=> (state == ST_UPDATE))
    else $error("compression did not end after the last round");

  a_out_drained: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending == 6'd0 && !extra && finishing))
    else $error("digest shown with padding outstanding");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_word)
      |=> (in_ready && hash == HASH_INIT && msg_count == 61'd0 && !finishing))
    else $error("hasher did not restart after the last digest word");
`endif

endmodule

>>> dv/sha256_byte_stream_hasher_test.sv
// Self-checking testbench for sha256_byte_stream_hasher: byte messages are hashed
// and every digest word is checked against an in-bench SHA-256 predictor.
// Depends on s256_pkg and the sha256_byte_stream_hasher RTL.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_test import s256_pkg::*;;

  localparam int QUIET_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 80;
  localparam int RANDOM_ITEMS  = 420;
  localparam int PAD_EDGES [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = OP_ABSORB;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  // predictor state
  logic [31:0] chain [8];
  logic [7:0]  blk [64];
  int          fill;
  logic [60:0] msg_len;

  digest_beat_t digest_q [$];
  int           errors = 0;
  int           items_sent = 0;
  int           quiet = 0;
  bit           steady = 1'b0;

  sha256_byte_stream_hasher dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void sha_restart();
    for (int i = 0; i < 8; i++) chain[i] = SHA_IV[i];
    fill    = 0;
    msg_len = '0;
  endfunction

  function automatic void sha_compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endfunction

  function automatic void sha_absorb(input logic [7:0] b);
    blk[fill] = b;
    fill++;
    msg_len++;
    if (fill == 64) begin
      sha_compress();
      fill = 0;
    end
  endfunction

  function automatic void sha_finish();
    logic [63:0] bit_len;
    digest_beat_t beat;
    bit_len = {msg_len, 3'b000};
    blk[fill] = 8'h80;
    fill++;
    if (fill > 56) begin
      for (int i = fill; i < 64; i++) blk[i] = 8'h00;
      sha_compress();
      fill = 0;
    end
    for (int i = fill; i < 56; i++) blk[i] = 8'h00;
    for (int i = 0; i < 8; i++) blk[56+i] = bit_len[63-8*i -: 8];
    sha_compress();
    for (int i = 0; i < 8; i++) begin
      beat.word  = chain[i];
      beat.index = 3'(i);
      beat.last  = (i == 7);
      digest_q.push_back(beat);
    end
    sha_restart();
  endfunction

  task automatic flag(input string what);
    errors++;
    if (errors <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // entered and left at a falling edge
  task automatic send_item(input logic op, input logic [7:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    if (op == OP_FINISH) sha_finish();
    else sha_absorb(b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic hash_message(input int len);
    for (int i = 0; i < len; i++) send_item(OP_ABSORB, 8'($urandom));
    send_item(OP_FINISH, 8'($urandom));
  endtask

  task automatic test_empty_message();
    send_item(OP_FINISH, 8'h00);
    send_item(OP_FINISH, 8'hff);
  endtask

  task automatic test_abc();
    send_item(OP_ABSORB, 8'h61);
    send_item(OP_ABSORB, 8'h62);
    send_item(OP_ABSORB, 8'h63);
    send_item(OP_FINISH, 8'h00);
  endtask

  task automatic test_byte_extremes();
    send_item(OP_ABSORB, 8'h00);
    send_item(OP_ABSORB, 8'hff);
    send_item(OP_ABSORB, 8'h00);
    send_item(OP_ABSORB, 8'hff);
    send_item(OP_ABSORB, 8'h80);
    send_item(OP_ABSORB, 8'h7f);
    send_item(OP_FINISH, 8'h55);
    steady = 1'b1;
    send_item(OP_ABSORB, 8'haa);
    send_item(OP_FINISH, 8'h00);
    send_item(OP_FINISH, 8'h00);
    steady = 1'b0;
  endtask

  // half short messages, the rest on the padding edges or of random length up to 130
  task automatic test_random_messages();
    int start;
    int pick;
    int len;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) len = $urandom_range(0, 15);
      else if (pick < 8) len = PAD_EDGES[$urandom_range(0, 7)];
      else len = $urandom_range(0, 130);
      steady = ($urandom_range(0, 3) == 0);
      hash_message(len);
    end
    steady = 1'b0;
  endtask

  // receiver: a fresh stall before each transaction
  initial begin
    int stall;
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && !rst));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    digest_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        flag($sformatf("unexpected word %h index %0d last %b",
                       digest_word, word_index, last_word));
      end else begin
        want = digest_q.pop_front();
        if (digest_word !== want.word)
          flag($sformatf("digest_word exp %h got %h", want.word, digest_word));
        if (word_index !== want.index)
          flag($sformatf("word_index exp %0d got %0d", want.index, word_index));
        if (last_word !== want.last)
          flag($sformatf("last_word exp %b got %b", want.last, last_word));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    sha_restart();
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_empty_message();
    test_abc();
    test_byte_extremes();
    test_random_messages();
    in_valid <= 1'b0;
    wait (digest_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && digest_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
